// File: rtl/core/plc_pkg.sv
`default_nettype none

package plc_pkg;

   localparam int unsigned ENTRY_COUNT = 16;
   localparam int unsigned ENTRY_BITS  = 4;
   localparam int unsigned COLOR_BITS  = 24;
   localparam int unsigned CHAN_BITS   = 8;
   localparam int unsigned INDEX_BITS  = 16;
   localparam int unsigned CSR_IDX_BITS  = 1;
   localparam int unsigned CSR_DATA_BITS = 1;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BLEND_ENABLE     = 1'b0,
      CSR_SCALE_FIXED_MODE = 1'b1
   } csr_index_type;

   localparam logic [CHAN_BITS-1:0] BRIGHT_FULL = 8'd255;
   localparam logic [CHAN_BITS-1:0] BRIGHT_OFF  = 8'd0;

endpackage

`default_nettype wire

// File: rtl/core/plc_if.sv
`default_nettype none

interface plc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic [plc_pkg::ENTRY_BITS-1:0]       entry_number;
   logic [plc_pkg::COLOR_BITS-1:0]       entry_color;
   logic [plc_pkg::INDEX_BITS-1:0]       color_index;
   logic [plc_pkg::CHAN_BITS-1:0]        brightness;

   modport source (output valid, opcode, entry_number, entry_color, color_index, brightness,
                   input ready);
   modport sink (input valid, opcode, entry_number, entry_color, color_index, brightness,
                 output ready);
endinterface

interface plc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [plc_pkg::CHAN_BITS-1:0] red;
   logic [plc_pkg::CHAN_BITS-1:0] green;
   logic [plc_pkg::CHAN_BITS-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: rtl/core/palette_color_lookup.sv
`default_nettype none

// Sixteen-entry RGB palette lookup with linear blend and brightness scaling.
// One beat per clock is taken on req_chan, write or lookup alike, unless a full
// stall holds req_chan.ready low. A write updates the palette at its accept edge
// and gives no rsp beat; a lookup issued on the next cycle already sees it. A
// lookup gives one rsp beat, registered through palette read, blend multiply,
// blend sum, brightness multiply and the output register, one stage each. Stages
// hold independently, so bubbles are squeezed out while rsp_chan stalls. The
// palette reads black after reset through per-entry valid bits; no clearing pass is needed.
module palette_color_lookup (
   input  wire logic                                clock,
   input  wire logic                                reset,
   plc_req_if.sink                                  req_chan,
   plc_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_write_enable,
   input  wire logic [plc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [plc_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   localparam int unsigned CW = plc_pkg::CHAN_BITS;
   localparam int unsigned EB = plc_pkg::ENTRY_BITS;
   localparam int unsigned PW = 2 * CW;   // product width, 8x9 fits below 2^16
   localparam int unsigned WW = CW + 1;   // weight width, blend weights up to 256, brightness weight up to 257

   // configuration
   logic blend_enable_ff;
   logic scale_fixed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_enable_ff <= 1'b1;
         scale_fixed_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         case (plc_pkg::csr_index_type'(csr_index))
            plc_pkg::CSR_BLEND_ENABLE:     blend_enable_ff <= csr_write_data[0];
            plc_pkg::CSR_SCALE_FIXED_MODE: scale_fixed_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // stage valids and per-stage ready
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic req_accept, lookup_accept, write_accept;

   assign rdy5 = !rsp_valid_ff || rsp_chan.ready;
   assign rdy4 = !s4_valid_ff || rdy5;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;

   assign req_chan.ready = rdy1;
   assign req_accept     = req_chan.valid && rdy1;
   assign lookup_accept  = req_accept && (req_chan.opcode == plc_pkg::OP_LOOKUP);
   assign write_accept   = req_accept && (req_chan.opcode == plc_pkg::OP_WRITE);

   // palette memory, valid bits give the black reset value
   logic [plc_pkg::COLOR_BITS-1:0]  pal_mem [plc_pkg::ENTRY_COUNT];
   logic [plc_pkg::ENTRY_COUNT-1:0] pal_valid_ff;

   always_ff @(posedge clock) begin
      if (write_accept) begin
         pal_mem[req_chan.entry_number] <= req_chan.entry_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (write_accept) begin
         pal_valid_ff[req_chan.entry_number] <= 1'b1;
      end
   end

   // stage 1: palette read
   logic [EB-1:0]                   hi_idx, nx_idx;
   logic [CW-1:0]                   frac_in;
   logic [plc_pkg::COLOR_BITS-1:0]  e1_ff, e2_ff;
   logic                            ev1_ff, ev2_ff;
   logic [CW-1:0]                   s1_frac_ff, s1_bright_ff;
   logic                            s1_blend_ff;

   assign hi_idx  = req_chan.color_index[plc_pkg::INDEX_BITS-1 -: EB];
   assign nx_idx  = hi_idx + EB'(1);
   assign frac_in = req_chan.color_index[plc_pkg::INDEX_BITS-EB-1 -: CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= lookup_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_accept) begin
         e1_ff        <= pal_mem[hi_idx];
         e2_ff        <= pal_mem[nx_idx];
         ev1_ff       <= pal_valid_ff[hi_idx];
         ev2_ff       <= pal_valid_ff[nx_idx];
         s1_frac_ff   <= frac_in;
         s1_bright_ff <= req_chan.brightness;
         s1_blend_ff  <= blend_enable_ff && (frac_in != '0);
      end
   end

   // stage 2: blend products
   logic [2:0][CW-1:0] c1_in, c2_in;
   logic [WW-1:0]      w1_in, w2_in;
   logic [2:0][PW-1:0] p1_ff, p2_ff;
   logic [2:0][CW-1:0] s2_c1_ff;
   logic [CW-1:0]      s2_bright_ff;
   logic               s2_blend_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c1_in[k] = ev1_ff ? e1_ff[k*CW +: CW] : '0;
         c2_in[k] = ev2_ff ? e2_ff[k*CW +: CW] : '0;
      end
      // fixed mode scales by b+1
      if (scale_fixed_ff) begin
         w1_in = WW'(9'd256 - {1'b0, s1_frac_ff});
         w2_in = {1'b0, s1_frac_ff} + WW'(1);
      end else begin
         w1_in = WW'(9'd255 - {1'b0, s1_frac_ff});
         w2_in = {1'b0, s1_frac_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            p1_ff[k] <= PW'(c1_in[k] * w1_in);
            p2_ff[k] <= PW'(c2_in[k] * w2_in);
         end
         s2_c1_ff     <= c1_in;
         s2_bright_ff <= s1_bright_ff;
         s2_blend_ff  <= s1_blend_ff;
      end
   end

   // stage 3: blend sum, wraps mod 256
   logic [2:0][CW-1:0] ch_in;
   logic [WW-1:0]      bw_in;
   logic [2:0][CW-1:0] s3_ch_ff;
   logic [WW-1:0]      s3_bw_ff;
   logic [CW-1:0]      s3_bright_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ch_in[k] = s2_blend_ff ? CW'(p1_ff[k][PW-1:CW] + p2_ff[k][PW-1:CW]) : s2_c1_ff[k];
      end
      // dimming multiplies by brightness+1, fixed mode adds one more
      bw_in = {1'b0, s2_bright_ff} + (scale_fixed_ff ? WW'(2) : WW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (rdy3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && s2_valid_ff) begin
         s3_ch_ff     <= ch_in;
         s3_bw_ff     <= bw_in;
         s3_bright_ff <= s2_bright_ff;
      end
   end

   // stage 4: brightness products
   logic [2:0][PW-1:0] dp_ff;
   logic [2:0][CW-1:0] s4_ch_ff;
   logic [CW-1:0]      s4_bright_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (rdy4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && s3_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            dp_ff[k] <= PW'(s3_ch_ff[k] * s3_bw_ff);
         end
         s4_ch_ff     <= s3_ch_ff;
         s4_bright_ff <= s3_bright_ff;
      end
   end

   // stage 5: output register
   logic [2:0][CW-1:0] out_in;
   logic [2:0][CW-1:0] out_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (s4_bright_ff == plc_pkg::BRIGHT_FULL) begin
            out_in[k] = s4_ch_ff[k];
         end else if (s4_bright_ff == plc_pkg::BRIGHT_OFF || s4_ch_ff[k] == '0) begin
            out_in[k] = '0;
         end else begin
            out_in[k] = dp_ff[k][PW-1:CW] + (scale_fixed_ff ? CW'(0) : CW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy5) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && s4_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red   = out_ff[2];
   assign rsp_chan.green = out_ff[1];
   assign rsp_chan.blue  = out_ff[0];

   // checks
   a_lookup_enters: assert property (@(posedge clock) disable iff (reset)
      lookup_accept |=> s1_valid_ff)
      else $error("accepted lookup did not enter stage 1");

   a_write_no_beat: assert property (@(posedge clock) disable iff (reset)
      (write_accept && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("palette write produced a pipeline beat");

   a_reset_black: assert property (@(posedge clock)
      $past(reset) |-> (pal_valid_ff == '0))
      else $error("palette valid bits not cleared by reset");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && rsp_valid_ff
       && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while every stage is held");

   a_dark_output: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && rdy5 && s4_bright_ff == plc_pkg::BRIGHT_OFF)
      |=> (out_ff == '0))
      else $error("zero brightness gave a nonblack beat");

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PIPE_LATENCY = 5;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned PHASE_BEATS  = 155;

   typedef struct {
      plc_pkg::opcode_type                 opcode;
      logic [plc_pkg::ENTRY_BITS-1:0]      entry_number;
      logic [plc_pkg::COLOR_BITS-1:0]      entry_color;
      logic [plc_pkg::INDEX_BITS-1:0]      color_index;
      logic [plc_pkg::CHAN_BITS-1:0]       brightness;
   } req_beat_type;

   typedef struct packed {
      logic [plc_pkg::CHAN_BITS-1:0] red;
      logic [plc_pkg::CHAN_BITS-1:0] green;
      logic [plc_pkg::CHAN_BITS-1:0] blue;
   } color_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [plc_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [plc_pkg::CSR_DATA_BITS-1:0] csr_write_data;

   plc_req_if req_if ();
   plc_rsp_if rsp_if ();

   palette_color_lookup DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state, kept in step with accepted beats and csr writes
   logic [plc_pkg::COLOR_BITS-1:0] palette_mirror [plc_pkg::ENTRY_COUNT];
   bit                             blend_on;
   bit                             fixed_scale_on;
   color_type                      expected_colors [$];

   int unsigned error_count;
   int unsigned writes_sent;
   int unsigned lookups_sent;
   int unsigned lookups_checked;
   int unsigned settings_applied;
   int unsigned burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [plc_pkg::CHAN_BITS-1:0] scale_chan(
         input logic [plc_pkg::CHAN_BITS-1:0] a,
         input logic [plc_pkg::CHAN_BITS-1:0] b);
      logic [16:0] product;
      if (fixed_scale_on) begin
         product = a * ({1'b0, b} + 9'd1);
      end else begin
         product = a * b;
      end
      return product[15:8];
   endfunction

   function automatic color_type predict_color(
         input logic [plc_pkg::INDEX_BITS-1:0] color_index,
         input logic [plc_pkg::CHAN_BITS-1:0] brightness);
      logic [plc_pkg::ENTRY_BITS-1:0] entry_sel;
      logic [plc_pkg::ENTRY_BITS-1:0] next_sel;
      logic [plc_pkg::CHAN_BITS-1:0]  fraction;
      logic [plc_pkg::COLOR_BITS-1:0] base_rgb;
      logic [plc_pkg::COLOR_BITS-1:0] next_rgb;
      logic [plc_pkg::CHAN_BITS-1:0]  chan [3];
      color_type                      result;
      int                             k;
      entry_sel = color_index[15:12];
      next_sel  = entry_sel + 4'd1;   // entry 15 wraps to entry 0
      fraction  = color_index[11:4];
      base_rgb  = palette_mirror[entry_sel];
      next_rgb  = palette_mirror[next_sel];
      for (k = 0; k < 3; k++) begin
         chan[k] = base_rgb[16 - 8*k +: 8];
         if (blend_on && fraction != 8'd0) begin
            // 8-bit wrapping sum
            chan[k] = scale_chan(chan[k], 8'd255 - fraction)
                    + scale_chan(next_rgb[16 - 8*k +: 8], fraction);
         end
         if (brightness == plc_pkg::BRIGHT_OFF) begin
            chan[k] = '0;
         end else if (brightness != plc_pkg::BRIGHT_FULL && chan[k] != 8'd0) begin
            chan[k] = scale_chan(chan[k], brightness + 8'd1);
            if (!fixed_scale_on) begin
               chan[k] = chan[k] + 8'd1;
            end
         end
      end
      result.red   = chan[0];
      result.green = chan[1];
      result.blue  = chan[2];
      return result;
   endfunction

   // track csr writes and accepted request beats
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               plc_pkg::CSR_BLEND_ENABLE:     blend_on       = csr_write_data[0];
               plc_pkg::CSR_SCALE_FIXED_MODE: fixed_scale_on = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            if (req_if.opcode == plc_pkg::OP_LOOKUP) begin
               expected_colors.insert(expected_colors.size(),
                                      predict_color(req_if.color_index, req_if.brightness));
               lookups_sent++;
            end else begin
               palette_mirror[req_if.entry_number] = req_if.entry_color;
               writes_sent++;
            end
         end
      end
   end

   function automatic void check_chan(input string name,
                                      input logic [plc_pkg::CHAN_BITS-1:0] want,
                                      input logic [plc_pkg::CHAN_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      color_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_colors.size() == 0) begin
            $error("rsp beat with nothing pending: red %0d green %0d blue %0d",
                   rsp_if.red, rsp_if.green, rsp_if.blue);
            error_count++;
         end else begin
            want = expected_colors.pop_front();
            check_chan("red", want.red, rsp_if.red);
            check_chan("green", want.green, rsp_if.green);
            check_chan("blue", want.blue, rsp_if.blue);
            lookups_checked++;
         end
      end
   end

   // receiver backpressure: switches at random among four ready modes
   initial begin : receiver
      int unsigned mode;
      int unsigned mode_left;
      rsp_if.ready = 1'b0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_if.ready <= (mode_left % 3 == 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("palette_color_lookup verification failed");
      $finish;
   end

   // sender works in bursts; valid only drops between bursts
   task automatic send_beat(input req_beat_type beat);
      int unsigned idle_gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            idle_gap = $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.opcode       <= beat.opcode;
      req_if.entry_number <= beat.entry_number;
      req_if.entry_color  <= beat.entry_color;
      req_if.color_index  <= beat.color_index;
      req_if.brightness   <= beat.brightness;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // waits first so the predictor has logged the last accepted beat
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   task automatic change_settings(input bit blend, input bit fixed_scale);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= plc_pkg::CSR_BLEND_ENABLE;
      csr_write_data   <= blend;
      @(posedge clock);
      csr_index        <= plc_pkg::CSR_SCALE_FIXED_MODE;
      csr_write_data   <= fixed_scale;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   // ignored fields carry random junk
   function automatic req_beat_type write_beat(input logic [plc_pkg::ENTRY_BITS-1:0] entry,
                                               input logic [plc_pkg::COLOR_BITS-1:0] color);
      req_beat_type b;
      b.opcode       = plc_pkg::OP_WRITE;
      b.entry_number = entry;
      b.entry_color  = color;
      b.color_index  = 16'($urandom);
      b.brightness   = 8'($urandom);
      return b;
   endfunction

   function automatic req_beat_type lookup_beat(input logic [plc_pkg::INDEX_BITS-1:0] index,
                                                input logic [plc_pkg::CHAN_BITS-1:0] bright);
      req_beat_type b;
      b.opcode       = plc_pkg::OP_LOOKUP;
      b.entry_number = 4'($urandom);
      b.entry_color  = 24'($urandom);
      b.color_index  = index;
      b.brightness   = bright;
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      b.opcode       = ($urandom_range(0, 3) == 0) ? plc_pkg::OP_WRITE : plc_pkg::OP_LOOKUP;
      b.entry_number = 4'($urandom);
      b.entry_color  = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom);
      b.color_index  = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         b.color_index[11:4] = 8'd0;
      end
      case ($urandom_range(0, 9))
         0:       b.brightness = plc_pkg::BRIGHT_OFF;
         1:       b.brightness = plc_pkg::BRIGHT_FULL;
         2:       b.brightness = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd254;
         default: b.brightness = 8'($urandom);
      endcase
      return b;
   endfunction

   task automatic test_reset_palette();
      send_beat(lookup_beat(16'hFFFF, plc_pkg::BRIGHT_FULL));
      send_beat(lookup_beat(16'h7A50, 8'd200));
   endtask

   task automatic test_palette_extremes();
      send_beat(write_beat(4'd15, 24'hFFFFFF));
      send_beat(write_beat(4'd0, 24'hFF00FF));
      send_beat(write_beat(4'd1, 24'h010101));
      send_beat(write_beat(4'd7, 24'h808080));
      send_beat(lookup_beat(16'hF000, plc_pkg::BRIGHT_FULL));
      send_beat(lookup_beat(16'hFFFF, plc_pkg::BRIGHT_FULL));   // blend across the wrap
      send_beat(lookup_beat(16'h0010, 8'd128));
      send_beat(lookup_beat(16'h0FF0, 8'd1));
      send_beat(lookup_beat(16'h7000, plc_pkg::BRIGHT_OFF));
      send_beat(lookup_beat(16'h123F, 8'd254));
   endtask

   task automatic test_settings_sweep();
      int s;
      for (s = 0; s < 4; s++) begin
         change_settings(s[0], s[1]);
         send_beat(lookup_beat(16'hFFF0, plc_pkg::BRIGHT_FULL));
         send_beat(lookup_beat(16'h0880, 8'd200));
         send_beat(lookup_beat(16'hF00F, 8'd1));
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       change_settings(1'b0, 1'b0);
            1:       change_settings(1'b1, 1'b1);
            2:       change_settings(1'b0, 1'b1);
            3:       change_settings(1'b1, 1'b0);
            default: change_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         repeat (PHASE_BEATS) send_beat(random_beat());
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.opcode       = plc_pkg::OP_WRITE;
      req_if.entry_number = '0;
      req_if.entry_color  = '0;
      req_if.color_index  = '0;
      req_if.brightness   = '0;
      csr_write_enable    = 1'b0;
      csr_index           = plc_pkg::CSR_BLEND_ENABLE;
      csr_write_data      = '0;
      foreach (palette_mirror[i]) palette_mirror[i] = '0;
      blend_on         = 1'b1;
      fixed_scale_on   = 1'b1;
      error_count      = 0;
      writes_sent      = 0;
      lookups_sent     = 0;
      lookups_checked  = 0;
      settings_applied = 0;
      burst_left       = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_palette();
      test_palette_extremes();
      test_settings_sweep();
      test_random_traffic();
      wait_idle();

      if (lookups_checked != lookups_sent) begin
         $error("lookups: expected %0d rsp beats, got %0d", lookups_sent, lookups_checked);
         error_count++;
      end

      $display("Covered %0d palette writes and %0d lookups (%0d checked) over %0d csr settings",
               writes_sent, lookups_sent, lookups_checked, settings_applied);
      $display("with bursty sender, mixed rsp backpressure, all blend and scale mode pairs.");
      if (error_count == 0) begin
         $display("palette_color_lookup verification clean");
      end else begin
         $display("palette_color_lookup verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
